### hw/rtl/zscore_normalize_top_macros.svh
// Assertion macros for the z-score normalizer.
`ifndef ZSCORE_NORMALIZE_TOP_MACROS_SVH
`define ZSCORE_NORMALIZE_TOP_MACROS_SVH

`ifndef SYNTH
`define ZSN_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("zsn assertion failed");
`define ZSN_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("zsn assertion failed");
`else
`define ZSN_ASSERT_IMP(label, ante, cons)
`define ZSN_ASSERT_NXT(label, ante, cons)
`endif

`endif

### hw/rtl/zsn_pkg.sv
// Shared types and constants of the z-score normalizer.
package zsn_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int IDX_W       = $clog2(MAX_SAMPLES);
	localparam int SUM_W       = 22;
	localparam int SQ_W        = 40;
	localparam int DVD_W       = 64;
	localparam int REM_W       = 34;
	localparam int ROOT_W      = 32;
	localparam int STEP_W      = 7;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          is_last;
	} zsn_in_t;

	typedef struct packed {
		logic signed [15:0] zscore;
		logic               out_last;
		logic               error;
	} zsn_out_t;

	typedef struct packed {
		logic load;
		logic stat_mul;
		logic stat_sub;
		logic nd_mul;
		logic vdiv_go;
		logic sqrt_go;
		logic rd;
		logic zmul;
		logic zsub;
		logic zgo;
		logic zlatch;
		logic adv;
		logic clr;
	} zsn_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic err;
		logic skip;
		logic last;
	} zsn_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUB,
		ST_ND,
		ST_VDIV_GO,
		ST_VDIV,
		ST_SQRT,
		ST_RD,
		ST_ZMUL,
		ST_ZSUB,
		ST_ZGO,
		ST_ZWAIT,
		ST_EMIT
	} zsn_state_t;

endpackage

### hw/rtl/zsn_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module zsn_div
	import zsn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [REM_W-1:0]  rem_init,
	input  logic [DVD_W-1:0]  dvd_init,
	input  logic [REM_W-1:0]  dsr,
	input  logic [STEP_W-1:0] steps,
	output logic              done,
	output logic [DVD_W-1:0]  quo
);

	logic [REM_W-1:0]  rem_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [REM_W-1:0]  dsr_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  trial;
	logic              qbit;
	logic [REM_W-1:0]  rem_nx;

	assign trial  = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
	assign qbit   = trial >= dsr_q;
	assign rem_nx = qbit ? trial - dsr_q : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && cnt_q == STEP_W'(1) && !go;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= rem_init;
			dvd_q <= dvd_init;
			dsr_q <= dsr;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = dvd_q;

endmodule

### hw/rtl/zsn_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module zsn_sqrt
	import zsn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [DVD_W-1:0]  v,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [DVD_W-1:0] v_q;
	logic [DVD_W-1:0] r_q;
	logic [DVD_W-1:0] bit_q;
	logic             busy_q;
	logic             done_q;
	logic [DVD_W-1:0] t;
	logic             ge;

	assign t  = r_q + bit_q;
	assign ge = v_q >= t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && bit_q[0] && !go;
			if (go)
				busy_q <= 1'b1;
			else if (busy_q && bit_q[0])
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			v_q   <= v;
			r_q   <= '0;
			bit_q <= {2'b01, {(DVD_W-2){1'b0}}};
		end else if (busy_q) begin
			v_q   <= ge ? v_q - t : v_q;
			r_q   <= ge ? (r_q >> 1) + bit_q : r_q >> 1;
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[ROOT_W-1:0];

endmodule

### hw/rtl/zsn_dp.sv
// Datapath: sample buffer, sums, statistics, shared divider and root unit.
module zsn_dp
	import zsn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  zsn_cmd_t cmd,
	input  zsn_in_t  item,
	output zsn_sts_t sts,
	output zsn_out_t result
);

	logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
	logic [CNT_W-1:0]              cnt_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SQ_W-1:0]               sq_q;
	logic [IDX_W-1:0]              idx_q;
	logic                          err_q;
	logic                          skip_q;
	logic                          sat_q;
	logic [46:0]                   nq_q;
	logic signed [43:0]            ss_q;
	logic [42:0]                   d_q;
	logic [49:0]                   nd_q;
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic signed [23:0]            nx_s;
	logic                          neg_q;
	logic [22:0]                   mag_q;
	zsn_out_t                      res_q;

	logic signed [31:0] xsq;
	logic signed [47:0] diff;
	logic signed [23:0] num;
	logic [41:0]        zdvd;
	logic [REM_W-1:0]   zdsr;
	logic               zsat;
	logic               div_go;
	logic [REM_W-1:0]   div_rem;
	logic [DVD_W-1:0]   div_dvd;
	logic [REM_W-1:0]   div_dsr;
	logic [STEP_W-1:0]  div_steps;
	logic               div_done;
	logic [DVD_W-1:0]   div_quo;
	logic               sqrt_done;
	logic [ROOT_W-1:0]  root;
	logic [16:0]        q17;
	logic               full;

	assign full = cnt_q == CNT_W'(MAX_SAMPLES);
	assign xsq  = item.sample * item.sample;
	assign diff = signed'({1'b0, nq_q}) - 48'(ss_q);
	assign num  = nx_s - 24'(sum_q);
	assign zdvd = {mag_q, 19'b0} + 42'(root);
	assign zdsr = REM_W'({root, 1'b0});
	assign zsat = REM_W'(zdvd[41:17]) >= zdsr;

	always_comb begin
		div_go    = cmd.vdiv_go || (cmd.zgo && !err_q && !zsat);
		div_rem   = '0;
		div_dvd   = {nd_q, 14'b0};
		div_dsr   = REM_W'(cnt_q - CNT_W'(1));
		div_steps = STEP_W'(DVD_W);
		if (cmd.zgo) begin
			div_rem   = REM_W'(zdvd[41:17]);
			div_dvd   = {zdvd[16:0], {(DVD_W-17){1'b0}}};
			div_dsr   = zdsr;
			div_steps = STEP_W'(17);
		end
	end

	zsn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.rem_init (div_rem),
		.dvd_init (div_dvd),
		.dsr      (div_dsr),
		.steps    (div_steps),
		.done     (div_done),
		.quo      (div_quo)
	);

	zsn_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.sqrt_go),
		.v      (div_quo),
		.done   (sqrt_done),
		.root   (root)
	);

	always_ff @(posedge clk) begin
		if (cmd.load && !full)
			mem[cnt_q[IDX_W-1:0]] <= item.sample;
		if (cmd.rd)
			rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			sq_q   <= '0;
			idx_q  <= '0;
			err_q  <= 1'b0;
			skip_q <= 1'b0;
			sat_q  <= 1'b0;
		end else begin
			if (cmd.clr) begin
				cnt_q <= '0;
				sum_q <= '0;
				sq_q  <= '0;
			end else if (cmd.load && !full) begin
				cnt_q <= cnt_q + CNT_W'(1);
				sum_q <= sum_q + SUM_W'(item.sample);
				sq_q  <= sq_q + SQ_W'(unsigned'(xsq));
			end
			if (cmd.stat_mul)
				idx_q <= '0;
			else if (cmd.adv)
				idx_q <= idx_q + IDX_W'(1);
			if (cmd.stat_sub)
				err_q <= cnt_q < CNT_W'(2) || diff <= 48'sd0;
			if (cmd.zgo) begin
				skip_q <= err_q || zsat;
				sat_q  <= zsat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.stat_mul) begin
			nq_q <= 47'(cnt_q) * sq_q;
			ss_q <= 44'(sum_q) * 44'(sum_q);
		end
		if (cmd.stat_sub)
			d_q <= diff < 48'sd0 ? '0 : diff[42:0];
		if (cmd.nd_mul)
			nd_q <= 50'(cnt_q) * 50'(d_q);
		if (cmd.zmul)
			nx_s <= signed'({1'b0, cnt_q}) * rd_q;
		if (cmd.zsub) begin
			neg_q <= num < 24'sd0;
			mag_q <= num < 24'sd0 ? 23'(-num) : num[22:0];
		end
		if (cmd.zlatch)
			res_q <= '{zscore: zval(), out_last: sts.last, error: err_q};
	end

	assign q17 = div_quo[16:0];

	function automatic logic signed [15:0] zval();
		logic signed [15:0] z;
		z = '0;
		if (!err_q) begin
			if (neg_q)
				z = (sat_q || q17 > 17'd32768) ? 16'sh8000 : 16'(-q17);
			else
				z = (sat_q || q17 > 17'd32767) ? 16'sh7fff : 16'(q17);
		end
		return z;
	endfunction

	assign sts.div_done  = div_done;
	assign sts.sqrt_done = sqrt_done;
	assign sts.err       = err_q;
	assign sts.skip      = skip_q;
	assign sts.last      = CNT_W'(idx_q) == cnt_q - CNT_W'(1);
	assign result        = res_q;

endmodule

### hw/rtl/zsn_ctrl.sv
// Controller state machine sequencing load, statistics and per-sample output.
module zsn_ctrl
	import zsn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     is_last,
	input  zsn_sts_t sts,
	output zsn_cmd_t cmd,
	output logic     busy,
	output logic     strobe
);

	zsn_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		strobe   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (is_last)
						state_nx = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.stat_mul = 1'b1;
				state_nx     = ST_SUB;
			end
			ST_SUB: begin
				cmd.stat_sub = 1'b1;
				state_nx     = ST_ND;
			end
			ST_ND: begin
				if (sts.err)
					state_nx = ST_RD;
				else begin
					cmd.nd_mul = 1'b1;
					state_nx   = ST_VDIV_GO;
				end
			end
			ST_VDIV_GO: begin
				cmd.vdiv_go = 1'b1;
				state_nx    = ST_VDIV;
			end
			ST_VDIV: begin
				if (sts.div_done) begin
					cmd.sqrt_go = 1'b1;
					state_nx    = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (sts.sqrt_done)
					state_nx = ST_RD;
			end
			ST_RD: begin
				cmd.rd   = 1'b1;
				state_nx = ST_ZMUL;
			end
			ST_ZMUL: begin
				cmd.zmul = 1'b1;
				state_nx = ST_ZSUB;
			end
			ST_ZSUB: begin
				cmd.zsub = 1'b1;
				state_nx = ST_ZGO;
			end
			ST_ZGO: begin
				cmd.zgo  = 1'b1;
				state_nx = ST_ZWAIT;
			end
			ST_ZWAIT: begin
				if (sts.skip || sts.div_done) begin
					cmd.zlatch = 1'b1;
					state_nx   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				strobe = 1'b1;
				if (sts.last) begin
					cmd.clr  = 1'b1;
					state_nx = ST_IDLE;
				end else begin
					cmd.adv  = 1'b1;
					state_nx = ST_RD;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	assign busy = state_q != ST_IDLE;

endmodule

### hw/rtl/zscore_normalize_top.sv
// Top level of the z-score normalizer.
// Samples load one per cycle while busy is low; a beat with is_last set ends
// the vector (at most 64 samples are kept, extras are dropped). The block
// then stays busy through the statistics (a 64-step division by n-1 and a
// 32-step square root) and then through each result in turn, which uses the
// 17-step shared divider; a saturated or error result skips the division.
// With fewer than two samples or zero deviation the statistics stop before the
// division and every beat carries zscore 0 and error set. Each result beat
// is marked by strobe high for a single cycle and cannot be held off.
`include "zscore_normalize_top_macros.svh"

module zscore_normalize_top
	import zsn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  zsn_in_t  item,
	output logic     strobe,
	output zsn_out_t result
);

	zsn_cmd_t cmd;
	zsn_sts_t sts;

	zsn_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.is_last (item.is_last),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy),
		.strobe  (strobe)
	);

	zsn_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.sts    (sts),
		.result (result)
	);

	`ZSN_ASSERT_IMP(a_strobe_busy, strobe, busy)
	`ZSN_ASSERT_NXT(a_strobe_gap, strobe, !strobe)
	`ZSN_ASSERT_NXT(a_last_idle, strobe && result.out_last, !busy)
	`ZSN_ASSERT_NXT(a_load_stays, start && !busy && !item.is_last, !busy)
	`ZSN_ASSERT_IMP(a_err_zero, strobe && result.error, result.zscore == 16'sd0)

endmodule
